[hw/rtl/tabular_q_learning_engine_top_assert.svh]
// assertion macros used by the q-learning engine top level
`ifndef TABULAR_Q_LEARNING_ENGINE_TOP_ASSERT_SVH
`define TABULAR_Q_LEARNING_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define TQLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TQLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tqle_pkg.sv]
// shared types and constants of the q-learning engine
package tqle_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT = 2'd3;

    localparam logic [15:0] LEARN_RATE_RST   = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST     = 16'd58982;
    localparam logic [15:0] EXPLORE_RST      = 16'd6554;
    localparam logic [3:0]  ACTION_COUNT_RST = 4'd8;

    localparam int STATE_IDX_W  = 8;
    localparam int ACTION_IDX_W = 3;
    localparam int COUNT_W      = 4;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_SELECT = 2'd1,
        FUNC_WRITE  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_CUR_RD,
        ST_TARGET,
        ST_MUL2,
        ST_EXP_RD,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_CUR,
        RD_EXPLORE
    } t_rd_sel;

    typedef struct packed {
        logic               capture;
        logic               rd_en;
        t_rd_sel            rd_sel;
        logic [COUNT_W-1:0] scan_col;
        logic               cmp_en;
        logic               cmp_first;
        logic [COUNT_W-1:0] cmp_idx;
        logic               mul1;
        logic               target;
        logic               mul2;
        logic               out_load;
        logic               wr_en;
    } t_cmd;

    typedef struct packed {
        t_func              func;
        logic               explore;
        logic [COUNT_W-1:0] n_eff;
    } t_status;

endpackage

[hw/rtl/tqle_ctrl.sv]
// sequencing state machine of the q-learning engine
module tqle_ctrl
    import tqle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_m_valid, n_m_valid;
    logic               w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;
    assign o_s_ready  = (r_state == ST_IDLE);
    assign o_m_valid  = r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_cnt = '0;
                case (i_status.func)
                    FUNC_UPDATE: n_state = ST_SCAN;
                    FUNC_SELECT: n_state = i_status.explore ? ST_EXP_RD : ST_SCAN;
                    default:     n_state = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                // read column r_cnt while comparing the word read last cycle
                o_cmd.rd_sel    = RD_SCAN;
                o_cmd.scan_col  = r_cnt;
                o_cmd.cmp_idx   = r_cnt - 4'd1;
                o_cmd.cmp_first = (r_cnt == 4'd1);
                o_cmd.cmp_en    = (r_cnt != 4'd0);
                if (r_cnt != i_status.n_eff) begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt       = r_cnt + 4'd1;
                end else begin
                    n_state = (i_status.func == FUNC_UPDATE) ? ST_CUR_RD : ST_RESULT;
                end
            end
            ST_CUR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                o_cmd.mul1   = 1'b1;
                n_state      = ST_TARGET;
            end
            ST_TARGET: begin
                o_cmd.target = 1'b1;
                n_state      = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_RESULT;
            end
            ST_EXP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_EXPLORE;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                // hold here until the output register can take the beat
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.wr_en    = (i_status.func == FUNC_UPDATE) ||
                                     (i_status.func == FUNC_WRITE);
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

endmodule

[hw/rtl/tqle_datapath.sv]
// value table, config registers, argmax and update arithmetic
module tqle_datapath
    import tqle_pkg::*;
#(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic [M_TUSER_W-1:0]  o_m_tuser
);

    localparam int ROW_W  = $clog2(NUM_STATES);
    localparam int COL_W  = $clog2(NUM_ACTIONS);
    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);

    // config registers
    logic [15:0]        r_learn_rate;
    logic [15:0]        r_discount;
    logic [15:0]        r_explore;
    logic [COUNT_W-1:0] r_action_count;

    // captured beat
    t_func                   r_func;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        r_ns_row;
    logic [ACTION_IDX_W-1:0] r_act;
    logic signed [31:0]      r_reward;
    logic [31:0]             r_wval;
    logic [ACTION_IDX_W-1:0] r_ract;
    logic                    r_explore_hit;

    // work registers
    logic [31:0]         r_rdata;
    logic signed [31:0]  r_best;
    logic [COUNT_W-1:0]  r_pick;
    logic signed [48:0]  r_prod1;
    logic signed [33:0]  r_target;
    logic signed [50:0]  r_prod2;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    logic [31:0] r_table [DEPTH];

    // index wrap tables
    logic [ROW_W-1:0] w_row_lut [2**STATE_IDX_W];
    logic [COL_W-1:0] w_col_lut [2**ACTION_IDX_W];

    for (genvar g = 0; g < 2**STATE_IDX_W; g++) begin : g_row_lut
        assign w_row_lut[g] = ROW_W'(g % NUM_STATES);
    end
    for (genvar g = 0; g < 2**ACTION_IDX_W; g++) begin : g_col_lut
        assign w_col_lut[g] = COL_W'(g % NUM_ACTIONS);
    end

    logic [STATE_IDX_W-1:0]  w_in_state;
    logic [ACTION_IDX_W-1:0] w_in_action;
    logic [STATE_IDX_W-1:0]  w_in_next;
    logic [31:0]             w_in_reward;
    logic [31:0]             w_in_wval;
    logic [15:0]             w_in_draw;
    logic [ACTION_IDX_W-1:0] w_in_ract;

    assign w_in_state  = i_s_tdata[7:0];
    assign w_in_action = i_s_tdata[10:8];
    assign w_in_next   = i_s_tdata[18:11];
    assign w_in_reward = i_s_tdata[50:19];
    assign w_in_wval   = i_s_tdata[82:51];
    assign w_in_draw   = i_s_tdata[98:83];
    assign w_in_ract   = i_s_tdata[101:99];

    logic [COUNT_W-1:0] w_n_eff;
    logic [COUNT_W-1:0] w_ract_ext;
    logic [COUNT_W-1:0] w_pick;
    logic [ROW_W-1:0]   w_rd_row;
    logic [ADDR_W-1:0]  w_rd_col;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic signed [35:0] w_nq;
    logic               w_ovf;
    logic [31:0]        w_q;
    logic [ACTION_IDX_W-1:0] w_chosen;
    logic               w_expl;
    logic               w_sat;

    // actions in use: zero acts as one, capped at the table width
    always_comb begin
        if (r_action_count == '0) begin
            w_n_eff = 4'd1;
        end else if (int'(r_action_count) > NUM_ACTIONS) begin
            w_n_eff = COUNT_W'(NUM_ACTIONS);
        end else begin
            w_n_eff = r_action_count;
        end
    end

    assign w_ract_ext = COUNT_W'(r_ract);
    assign w_pick     = (w_ract_ext > w_n_eff - 4'd1) ? w_n_eff - 4'd1 : w_ract_ext;

    assign o_status.func    = r_func;
    assign o_status.explore = r_explore_hit;
    assign o_status.n_eff   = w_n_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= LEARN_RATE_RST;
            r_discount     <= DISCOUNT_RST;
            r_explore      <= EXPLORE_RST;
            r_action_count <= ACTION_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_wdata;
                CFG_DISCOUNT:     r_discount     <= i_cfg_wdata;
                CFG_EXPLORE:      r_explore      <= i_cfg_wdata;
                CFG_ACTION_COUNT: r_action_count <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func        <= t_func'(i_s_tuser);
            r_row         <= w_row_lut[w_in_state];
            r_ns_row      <= w_row_lut[w_in_next];
            r_act         <= w_in_action;
            r_reward      <= $signed(w_in_reward);
            r_wval        <= w_in_wval;
            r_ract        <= w_in_ract;
            r_explore_hit <= (w_in_draw < r_explore);
        end
    end

    // table addressing
    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN: begin
                w_rd_row = (r_func == FUNC_UPDATE) ? r_ns_row : r_row;
                w_rd_col = ADDR_W'(i_cmd.scan_col);
            end
            RD_EXPLORE: begin
                w_rd_row = r_row;
                w_rd_col = ADDR_W'(w_pick);
            end
            default: begin
                w_rd_row = r_row;
                w_rd_col = ADDR_W'(w_col_lut[r_act]);
            end
        endcase
    end

    assign w_rd_addr = ADDR_W'(w_rd_row) * ADDR_W'(NUM_ACTIONS) + w_rd_col;
    assign w_wr_addr = ADDR_W'(r_row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(w_col_lut[r_act]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_table[w_wr_addr] <= w_q;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_table[w_rd_addr];
        end
    end

    // running row maximum, first maximum wins
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            if (i_cmd.cmp_first || ($signed(r_rdata) > r_best)) begin
                r_best <= $signed(r_rdata);
                r_pick <= i_cmd.cmp_idx;
            end
        end
    end

    // gamma * max, then target error, then alpha * error
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod1 <= r_best * $signed({1'b0, r_discount});
        end
        if (i_cmd.target) begin
            r_target <= 34'(r_reward) + 34'($signed(r_prod1[48:16]))
                        - 34'($signed(r_rdata));
        end
        if (i_cmd.mul2) begin
            r_prod2 <= r_target * $signed({1'b0, r_learn_rate});
        end
    end

    assign w_nq  = 36'($signed(r_rdata)) + 36'($signed(r_prod2[50:16]));
    assign w_ovf = !((&w_nq[35:31]) || (~|w_nq[35:31]));

    always_comb begin
        w_q      = '0;
        w_chosen = r_act;
        w_expl   = 1'b0;
        w_sat    = 1'b0;
        case (r_func)
            FUNC_UPDATE: begin
                w_sat = w_ovf;
                if (w_ovf) begin
                    w_q = w_nq[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    w_q = w_nq[31:0];
                end
            end
            FUNC_SELECT: begin
                if (r_explore_hit) begin
                    w_chosen = w_pick[ACTION_IDX_W-1:0];
                    w_q      = r_rdata;
                    w_expl   = 1'b1;
                end else begin
                    w_chosen = r_pick[ACTION_IDX_W-1:0];
                    w_q      = r_best;
                end
            end
            FUNC_WRITE: w_q = r_wval;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tdata <= {5'd0, w_q, w_chosen};
            r_m_tuser <= {w_sat, w_expl};
        end
    end

    assign o_m_tdata = r_m_tdata;
    assign o_m_tuser = r_m_tuser;

endmodule

[hw/rtl/tabular_q_learning_engine_top.sv]
// top level of the tabular q-learning engine with epsilon-greedy select
//
//  channel | direction | handshake                     | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready | tdata 104b, tuser 2b
//  m_axis  | out       | m_axis_tvalid / m_axis_tready | tdata 40b, tuser 2b
//  cfg     | in        | i_cfg_we (no wait)            | i_cfg_addr 2b, i_cfg_wdata 16b
//
// one item at a time; n = actions in use. steps from accept: decode; for update a scan
// of n words, current read, target, second multiply; for greedy select a scan; for
// exploring select a read; then result, then idle. the scan reads one word per cycle.
// reset is synchronous and clears the control and config registers; the table
// holds no reset state. a new beat is taken while a finished result waits on m_axis,
// and a second result holds the engine in its result step until m_axis takes the first.
`include "tabular_q_learning_engine_top_assert.svh"

module tabular_q_learning_engine_top
    import tqle_pkg::*;
#(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // state row, action, next row, reward, write_value,
    // random_draw, random_action, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // chosen_action, q_value, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // explored, saturated
    output logic [M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    tqle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    tqle_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

    `TQLE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken while an item is in work")
    `TQLE_ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n,
        w_cmd.out_load, !m_axis_tvalid || m_axis_tready,
        "result overwritten before it was taken")
    `TQLE_ASSERT_SAME(a_write_with_result, i_clk, i_rst_n,
        w_cmd.wr_en, w_cmd.out_load,
        "table written outside the result cycle")
    `TQLE_ASSERT_SAME(a_sat_not_explore, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0],
        "saturated and explored flags both set")

endmodule
